// ----- rtl/core/mmbm_pkg.sv -----
`default_nettype none
package mmbm_pkg;

  localparam int WRAM_BYTES = 32768;
  localparam int WRAM_AW    = $clog2(WRAM_BYTES);

  localparam logic [7:0] FIXED_UPPER_BANK = 8'd7;

  // command codes
  localparam logic [1:0] CMD_READ  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  // read source codes
  localparam logic [2:0] SRC_OPEN   = 3'd0;
  localparam logic [2:0] SRC_STATUS = 3'd1;
  localparam logic [2:0] SRC_WRAM   = 3'd2;
  localparam logic [2:0] SRC_ROM    = 3'd3;
  localparam logic [2:0] SRC_GAME   = 3'd4;

  // config register indexes
  localparam logic [1:0] REG_CHR_PAGES = 2'd0;
  localparam logic [1:0] REG_VERSION   = 2'd1;
  localparam logic [1:0] REG_LAUNCH    = 2'd2;

  localparam logic [8:0] CHR_PAGES_RST = 9'd1;
  localparam logic [7:0] VERSION_RST   = 8'd1;
  localparam logic [7:0] LAUNCH_RST    = 8'd165;

  // register addresses
  localparam logic [15:0] ADDR_MODE    = 16'h5000;
  localparam logic [15:0] ADDR_OFF_LO  = 16'h5001;
  localparam logic [15:0] ADDR_OFF_HI  = 16'h5002;
  localparam logic [15:0] ADDR_SIZE_LO = 16'h5003;
  localparam logic [15:0] ADDR_SIZE_HI = 16'h5004;
  localparam logic [15:0] ADDR_IDX_LO  = 16'h5005;
  localparam logic [15:0] ADDR_IDX_HI  = 16'h5006;
  localparam logic [15:0] ADDR_LAUNCH  = 16'h500A;

  // menu register selects, address low bits
  localparam logic [2:0] SEL_PRG   = 3'd1;
  localparam logic [2:0] SEL_CHR   = 3'd2;
  localparam logic [2:0] SEL_SRAM  = 3'd3;

  localparam logic [2:0] STAT_VERSION = 3'd6;
  localparam logic [2:0] STAT_VER_LOW = 3'd7;

endpackage
`default_nettype wire

// ----- rtl/core/mmbm_if.sv -----
`default_nettype none
interface mmbm_req_if;
  import mmbm_pkg::*;

  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [15:0] address;
  logic [7:0]  write_data;

  modport source (output valid, command, address, write_data, input ready);
  modport sink   (input valid, command, address, write_data, output ready);
endinterface

interface mmbm_rsp_if;
  import mmbm_pkg::*;

  logic        valid;
  logic        ready;
  logic [2:0]  read_source;
  logic [7:0]  read_data;
  logic [21:0] rom_address;
  logic [7:0]  chr_page;
  logic        mirror_horizontal;
  logic        sram_mapped;
  logic        game_running;
  logic        launch_pulse;
  logic [15:0] game_offset;
  logic [15:0] game_size;
  logic [15:0] game_index;

  modport source (output valid, read_source, read_data, rom_address, chr_page,
                  mirror_horizontal, sram_mapped, game_running, launch_pulse,
                  game_offset, game_size, game_index, input ready);
  modport sink   (input valid, read_source, read_data, rom_address, chr_page,
                  mirror_horizontal, sram_mapped, game_running, launch_pulse,
                  game_offset, game_size, game_index, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/multicart_menu_bank_mapper.sv -----
// Cartridge menu mapper on the CPU bus.
// req: one beat per CPU read, CPU write or CPU clock tick (command, address,
//   write_data), valid/ready. rsp: one beat per req beat, in order, with the
//   read source and data, PRG ROM address, CHR page, mirroring and the game
//   registers as they stand after the access.
// cfg: write enable, index and data for chr_ram_pages (0), version_code (1)
//   and launch_code (2); write only while no beat is in flight.
// Throughput: one beat per cycle unless rsp stalls. Register state updates
//   in the accept cycle; the 32 KB work RAM is a single-port synchronous
//   memory, written and read in the accept cycle, so there is no hazard.
// From req accept to rsp valid a beat passes the RAM read stage, then the
//   output register. Two beats can be held, so one more req beat is taken
//   while rsp is stalled; after that req.ready drops until rsp.ready.
// Reset (rst, synchronous): menu mode, all bank/game registers zero, lock
//   clear, config registers to 1, 1, 165. Work RAM is not cleared; reading a
//   byte never written returns garbage. No clearing pass, ready right away.
// Running mode is left only by reset.
`default_nettype none
module multicart_menu_bank_mapper (
  input  wire logic                 clk,
  input  wire logic                 rst,
  mmbm_req_if.sink                  req,
  mmbm_rsp_if.source                rsp,
  input  wire logic                 cfg_we,
  input  wire logic [1:0]           cfg_index,
  input  wire logic [8:0]           cfg_wdata
);
  import mmbm_pkg::*;

  typedef enum logic [1:0] {MODE_MENU, MODE_CONFIG, MODE_RUNNING} mode_t;

  typedef struct packed {
    logic [2:0]  src;
    logic [7:0]  data;
    logic [21:0] rom;
    logic [7:0]  chr;
    logic        mirror;
    logic        sram_map;
    logic        running;
    logic        launch;
    logic [15:0] off;
    logic [15:0] size;
    logic [15:0] idx;
  } beat_t;

  // config
  logic [8:0] chr_pages;
  logic [7:0] version;
  logic [7:0] launch_code;

  // mapper state
  mode_t       mode, mode_next;
  logic [7:0]  prg_bank, prg_bank_next;
  logic [7:0]  chr_bank, chr_bank_next;
  logic [7:0]  applied_chr, applied_chr_next;
  logic [1:0]  sram_page, sram_page_next;
  logic [1:0]  flags, flags_next;
  logic [15:0] off_reg, off_next;
  logic [15:0] size_reg, size_next;
  logic [15:0] idx_reg, idx_next;
  logic        wlock, wlock_next;

  logic [7:0] wram [WRAM_BYTES];
  logic [7:0] ram_q;
  logic [WRAM_AW-1:0] wram_addr;
  logic       wram_we;
  logic       wram_vis;

  logic        req_fire;
  logic        a_valid, b_valid, a_adv;
  beat_t       a_beat, b_beat, beat_next, a_out;
  logic        do_sync;
  logic [1:0]  cmd;
  logic [15:0] addr;
  logic [7:0]  wdat;

  assign cmd  = req.command;
  assign addr = req.address;
  assign wdat = req.write_data;

  assign a_adv     = a_valid && (!b_valid || rsp.ready);
  assign req.ready = !rst && (!a_valid || a_adv);
  assign req_fire  = req.valid && req.ready;

  assign wram_vis  = (mode == MODE_MENU) && flags[0] && (addr[15:13] == 3'b011);
  assign wram_addr = {sram_page, addr[12:0]};

  always_comb begin
    mode_next      = mode;
    prg_bank_next  = prg_bank;
    chr_bank_next  = chr_bank;
    sram_page_next = sram_page;
    flags_next     = flags;
    off_next       = off_reg;
    size_next      = size_reg;
    idx_next       = idx_reg;
    wlock_next     = wlock;
    wram_we        = 1'b0;
    do_sync        = 1'b0;
    beat_next      = '0;
    beat_next.src  = SRC_OPEN;
    if (req_fire) begin
      case (cmd)
        CMD_READ: begin
          if (mode == MODE_RUNNING) begin
            beat_next.src = SRC_GAME;
          end else if (wram_vis) begin
            beat_next.src = SRC_WRAM;
          end else if (addr[15]) begin
            beat_next.src = SRC_ROM;
            beat_next.rom = {(addr[14] ? FIXED_UPPER_BANK : prg_bank), addr[13:0]};
          end else if (addr[2:0] == STAT_VERSION) begin
            beat_next.src  = SRC_STATUS;
            beat_next.data = version;
          end else if (addr[2:0] == STAT_VER_LOW) begin
            beat_next.src  = SRC_STATUS;
            beat_next.data = {5'd0, version[2:0]};
          end
        end
        CMD_WRITE: begin
          if (mode != MODE_RUNNING) begin
            wram_we = wram_vis;
            if (!wlock) begin
              wlock_next = 1'b1;
              if (addr == ADDR_MODE) begin
                if (wdat == 8'd0) begin
                  mode_next = MODE_MENU;
                  do_sync   = 1'b1;
                end else if (wdat == 8'd1) begin
                  mode_next = MODE_CONFIG;
                  off_next  = '0;
                  size_next = '0;
                  idx_next  = '0;
                end
              end else if (mode == MODE_MENU && addr > ADDR_MODE && addr < ADDR_IDX_LO) begin
                do_sync = 1'b1;
                case (addr[2:0])
                  SEL_PRG:  prg_bank_next  = wdat;
                  SEL_CHR:  chr_bank_next  = wdat;
                  SEL_SRAM: sram_page_next = wdat[1:0];
                  default:  flags_next     = wdat[1:0];
                endcase
              end else if (mode == MODE_CONFIG) begin
                case (addr)
                  ADDR_OFF_LO:  off_next  = {8'd0, wdat};
                  ADDR_OFF_HI:  off_next  = {wdat, off_reg[7:0]};
                  ADDR_SIZE_LO: size_next = {8'd0, wdat};
                  ADDR_SIZE_HI: size_next = {wdat, size_reg[7:0]};
                  ADDR_IDX_LO:  idx_next  = {8'd0, wdat};
                  ADDR_IDX_HI:  idx_next  = {wdat, idx_reg[7:0]};
                  ADDR_LAUNCH: begin
                    if (wdat == launch_code) begin
                      mode_next        = MODE_RUNNING;
                      beat_next.launch = 1'b1;
                    end
                  end
                  default: ;
                endcase
              end
            end
          end
        end
        CMD_TICK: wlock_next = 1'b0;
        default: ;
      endcase
      if (cmd != CMD_READ && mode == MODE_RUNNING) begin
        beat_next.src = SRC_GAME;
      end
    end
    applied_chr_next = applied_chr;
    if (do_sync && (({1'b0, chr_bank_next} + 9'd1) <= chr_pages)) begin
      applied_chr_next = chr_bank_next;
    end
    beat_next.chr      = applied_chr_next;
    beat_next.mirror   = flags_next[1];
    beat_next.sram_map = (mode_next == MODE_MENU) && flags_next[0];
    beat_next.running  = (mode_next == MODE_RUNNING);
    beat_next.off      = off_next;
    beat_next.size     = size_next;
    beat_next.idx      = idx_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chr_pages   <= CHR_PAGES_RST;
      version     <= VERSION_RST;
      launch_code <= LAUNCH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CHR_PAGES: chr_pages   <= cfg_wdata;
        REG_VERSION:   version     <= cfg_wdata[7:0];
        REG_LAUNCH:    launch_code <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_MENU;
      prg_bank    <= '0;
      chr_bank    <= '0;
      applied_chr <= '0;
      sram_page   <= '0;
      flags       <= '0;
      off_reg     <= '0;
      size_reg    <= '0;
      idx_reg     <= '0;
      wlock       <= 1'b0;
    end else if (req_fire) begin
      mode        <= mode_next;
      prg_bank    <= prg_bank_next;
      chr_bank    <= chr_bank_next;
      applied_chr <= applied_chr_next;
      sram_page   <= sram_page_next;
      flags       <= flags_next;
      off_reg     <= off_next;
      size_reg    <= size_next;
      idx_reg     <= idx_next;
      wlock       <= wlock_next;
    end
  end

  // work RAM: write and read in the accept cycle, read-first
  always_ff @(posedge clk) begin
    if (wram_we) begin
      wram[wram_addr] <= wdat;
    end
    if (req_fire) begin
      ram_q <= wram[wram_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
    end else begin
      if (req_fire) begin
        a_valid <= 1'b1;
      end else if (a_adv) begin
        a_valid <= 1'b0;
      end
      if (a_adv) begin
        b_valid <= 1'b1;
      end else if (rsp.ready) begin
        b_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    a_out = a_beat;
    if (a_beat.src == SRC_WRAM) begin
      a_out.data = ram_q;
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire) begin
      a_beat <= beat_next;
    end
    if (a_adv) begin
      b_beat <= a_out;
    end
  end

  assign rsp.valid             = b_valid;
  assign rsp.read_source       = b_beat.src;
  assign rsp.read_data         = b_beat.data;
  assign rsp.rom_address       = b_beat.rom;
  assign rsp.chr_page          = b_beat.chr;
  assign rsp.mirror_horizontal = b_beat.mirror;
  assign rsp.sram_mapped       = b_beat.sram_map;
  assign rsp.game_running      = b_beat.running;
  assign rsp.launch_pulse      = b_beat.launch;
  assign rsp.game_offset       = b_beat.off;
  assign rsp.game_size         = b_beat.size;
  assign rsp.game_index        = b_beat.idx;

endmodule
`default_nettype wire

// ----- rtl/core/mmbm_checker.sv -----
`default_nettype none
module mmbm_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       rsp_valid,
  input wire logic       rsp_ready,
  input wire logic [2:0] read_source,
  input wire logic       sram_mapped,
  input wire logic       game_running,
  input wire logic       launch_pulse
);
  import mmbm_pkg::*;

  a_rst_idle: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("rsp valid right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(read_source))
    else $error("rsp beat dropped or changed under stall");

  a_launch_runs: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && launch_pulse |-> game_running && read_source == SRC_OPEN)
    else $error("launch beat not in running mode");

  a_game_src: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && read_source == SRC_GAME |-> game_running && !launch_pulse)
    else $error("passed-through beat outside running mode");

  a_sram_menu: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && sram_mapped |-> !game_running)
    else $error("work RAM mapped while running");

endmodule

bind multicart_menu_bank_mapper mmbm_checker u_mmbm_checker (
  .clk          (clk),
  .rst          (rst),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .read_source  (rsp.read_source),
  .sram_mapped  (rsp.sram_mapped),
  .game_running (rsp.game_running),
  .launch_pulse (rsp.launch_pulse)
);
`default_nettype wire
